### design/wtnc_pkg.sv
// Shared types, codes and pattern tables of the wall tile classifier.
package wtnc_pkg;

  // Width used to compare 5-bit coordinates with grid sizes of up to 64.
  localparam int CMP_W = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_GATE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_GATE_ROW    = 2'd1;
  localparam logic [1:0] CFG_GATE_COL    = 2'd2;

  localparam logic       GATE_ENABLE_RST = 1'b1;
  localparam logic [4:0] GATE_ROW_RST    = 5'd11;
  localparam logic [4:0] GATE_COL_RST    = 5'd9;

  localparam logic [4:0] TILE_EMPTY       = 5'd0;
  localparam logic [4:0] TILE_HORIZ       = 5'd1;
  localparam logic [4:0] TILE_VERT        = 5'd2;
  localparam logic [4:0] TILE_TEE_UP      = 5'd3;
  localparam logic [4:0] TILE_TEE_DOWN    = 5'd4;
  localparam logic [4:0] TILE_TEE_LEFT    = 5'd5;
  localparam logic [4:0] TILE_TEE_RIGHT   = 5'd6;
  localparam logic [4:0] TILE_CORNER_LD   = 5'd7;
  localparam logic [4:0] TILE_CORNER_LU   = 5'd8;
  localparam logic [4:0] TILE_CORNER_UR   = 5'd9;
  localparam logic [4:0] TILE_CORNER_DR   = 5'd10;
  localparam logic [4:0] TILE_END_UP      = 5'd11;
  localparam logic [4:0] TILE_END_DOWN    = 5'd12;
  localparam logic [4:0] TILE_END_LEFT    = 5'd13;
  localparam logic [4:0] TILE_END_RIGHT   = 5'd14;
  localparam logic [4:0] TILE_CROSS       = 5'd15;
  localparam logic [4:0] TILE_GATE_L      = 5'd16;
  localparam logic [4:0] TILE_ISOLATED    = 5'd19;

  // Which of the three grid rows around the addressed cell is read.
  typedef enum logic [1:0] {
    SLOT_UP,
    SLOT_MID,
    SLOT_DN
  } slot_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    slot_t rd_slot;
    logic  cap_en;
    slot_t cap_slot;
    logic  mem_wr;
    logic  out_load;
  } wtnc_cmd_t;

  typedef struct packed {
    logic op_query;
    logic in_grid;
    logic out_busy;
  } wtnc_sts_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } rule_hit_t;

  // Full 8-neighbour patterns, bits UL UM UR ML MR LL LM LR from 7 down to 0.
  function automatic rule_hit_t full_rule(input logic [7:0] pat);
    rule_hit_t res;
    res.hit  = 1'b1;
    res.code = TILE_EMPTY;
    case (pat)
      8'hF8, 8'hF9, 8'hFC, 8'hFD,
      8'h1F, 8'h9F, 8'h3F, 8'hBF: res.code = TILE_HORIZ;
      8'hFA: res.code = TILE_TEE_UP;
      8'h7B: res.code = TILE_TEE_RIGHT;
      8'h5F: res.code = TILE_TEE_DOWN;
      8'hDE: res.code = TILE_TEE_LEFT;
      8'h6B, 8'h6F, 8'hEB, 8'hEF,
      8'hD6, 8'hD7, 8'hF6, 8'hF7: res.code = TILE_VERT;
      8'hFB: res.code = TILE_CORNER_LD;
      8'h7F: res.code = TILE_CORNER_LU;
      8'hDF: res.code = TILE_CORNER_UR;
      8'hFE: res.code = TILE_CORNER_DR;
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

  // Orthogonal fallback, indexed by UM ML MR LM.
  function automatic logic [4:0] orth_code(input logic [3:0] idx);
    logic [4:0] code;
    case (idx)
      4'd0:  code = TILE_ISOLATED;
      4'd1:  code = TILE_END_UP;
      4'd2:  code = TILE_END_LEFT;
      4'd3:  code = TILE_CORNER_DR;
      4'd4:  code = TILE_END_RIGHT;
      4'd5:  code = TILE_CORNER_LD;
      4'd6:  code = TILE_HORIZ;
      4'd7:  code = TILE_TEE_UP;
      4'd8:  code = TILE_END_DOWN;
      4'd9:  code = TILE_VERT;
      4'd10: code = TILE_CORNER_UR;
      4'd11: code = TILE_TEE_LEFT;
      4'd12: code = TILE_CORNER_LU;
      4'd13: code = TILE_TEE_RIGHT;
      4'd14: code = TILE_TEE_DOWN;
      4'd15: code = TILE_CROSS;
      default: code = TILE_EMPTY;
    endcase
    return code;
  endfunction

endpackage

### design/wtnc_ctrl.sv
// Sequencer that steps writes and queries through the row memory.
module wtnc_ctrl import wtnc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  wtnc_sts_t sts,
  output wtnc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_UP,
    S_RD_MID,
    S_RD_DN,
    S_CAP_DN,
    S_CLASSIFY,
    S_WR_RD,
    S_WR_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_slot  = SLOT_MID;
    cmd.cap_slot = SLOT_MID;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.in_grid) begin
          state_nxt = sts.op_query ? S_CLASSIFY : S_IDLE;
        end else begin
          state_nxt = sts.op_query ? S_RD_UP : S_WR_RD;
        end
      end
      S_RD_UP: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_slot = SLOT_UP;
        state_nxt   = S_RD_MID;
      end
      S_RD_MID: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = SLOT_MID;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = SLOT_UP;
        state_nxt    = S_RD_DN;
      end
      S_RD_DN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_slot  = SLOT_DN;
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = SLOT_MID;
        state_nxt    = S_CAP_DN;
      end
      S_CAP_DN: begin
        cmd.cap_en   = 1'b1;
        cmd.cap_slot = SLOT_DN;
        state_nxt    = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        // Hold the result until the output register is free.
        if (!sts.out_busy || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WR_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_slot = SLOT_MID;
        state_nxt   = S_WR_WR;
      end
      S_WR_WR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

endmodule

### design/wtnc_dp.sv
// Datapath: configuration, row memory, neighbour window and tile code logic.
module wtnc_dp import wtnc_pkg::*; #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_op,
  input  logic [4:0] in_row,
  input  logic [4:0] in_col,
  input  logic       in_cell_value,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [4:0] out_tile_code,
  input  wtnc_cmd_t  cmd,
  output wtnc_sts_t  sts
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CI  = $clog2(GRID_COLS);
  localparam int CXW = $clog2(GRID_COLS + 2);

  logic       gate_enable_r;
  logic [4:0] gate_row_r;
  logic [4:0] gate_col_r;

  logic       op_r;
  logic [4:0] row_r;
  logic [4:0] col_r;
  logic       val_r;

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] row_vld_r;
  logic [GRID_COLS-1:0] rd_raw_r;
  logic                 rd_keep_r;
  logic [GRID_COLS-1:0] rd_word;
  logic [GRID_COLS-1:0] wr_word;
  logic [GRID_COLS-1:0] up_r, mid_r, dn_r;

  logic          in_grid;
  logic [RW-1:0] mid_addr, up_addr, dn_addr, rd_addr;
  logic          up_exist, dn_exist, rd_exist;

  logic [GRID_COLS+1:0] up_ext, mid_ext, dn_ext;
  logic [CXW-1:0]       cx;
  logic [2:0]           up3, mid3, dn3;
  logic [7:0]           pat;
  rule_hit_t            full_hit;
  logic                 gate_hit;
  logic [4:0]           code_nxt;

  logic       out_valid_r;
  logic [4:0] out_tile_code_r;

  assign out_valid     = out_valid_r;
  assign out_tile_code = out_tile_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_enable_r <= GATE_ENABLE_RST;
      gate_row_r    <= GATE_ROW_RST;
      gate_col_r    <= GATE_COL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GATE_ENABLE: gate_enable_r <= cfg_data[0];
        CFG_GATE_ROW:    gate_row_r    <= cfg_data;
        CFG_GATE_COL:    gate_col_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_cell_value;
    end
  end

  assign in_grid = ({2'b00, row_r} < CMP_W'(GRID_ROWS)) &&
                   ({2'b00, col_r} < CMP_W'(GRID_COLS));

  assign sts.op_query = (op_r == OP_QUERY);
  assign sts.in_grid  = in_grid;
  assign sts.out_busy = out_valid_r;

  assign mid_addr = RW'(row_r);
  assign up_addr  = mid_addr - RW'(1);
  assign dn_addr  = mid_addr + RW'(1);
  assign up_exist = (row_r != 5'd0);
  assign dn_exist = ({2'b00, row_r} + CMP_W'(1)) < CMP_W'(GRID_ROWS);

  always_comb begin
    case (cmd.rd_slot)
      SLOT_UP: begin
        rd_addr  = up_addr;
        rd_exist = up_exist;
      end
      SLOT_DN: begin
        rd_addr  = dn_addr;
        rd_exist = dn_exist;
      end
      default: begin
        rd_addr  = mid_addr;
        rd_exist = 1'b1;
      end
    endcase
  end

  // Rows never written since reset read as all free.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_raw_r  <= mem[rd_addr];
      rd_keep_r <= rd_exist && row_vld_r[rd_addr];
    end
    if (cmd.mem_wr) begin
      mem[mid_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.mem_wr) begin
      row_vld_r[mid_addr] <= 1'b1;
    end
  end

  assign rd_word = rd_keep_r ? rd_raw_r : '0;

  always_comb begin
    wr_word              = rd_word;
    wr_word[CI'(col_r)]  = val_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_slot)
        SLOT_UP:  up_r  <= rd_word;
        SLOT_DN:  dn_r  <= rd_word;
        default:  mid_r <= rd_word;
      endcase
    end
  end

  // A zero column on each side makes off-grid neighbours read as free.
  assign up_ext  = {1'b0, up_r, 1'b0};
  assign mid_ext = {1'b0, mid_r, 1'b0};
  assign dn_ext  = {1'b0, dn_r, 1'b0};
  assign cx      = CXW'(col_r);
  assign up3     = up_ext[cx +: 3];
  assign mid3    = mid_ext[cx +: 3];
  assign dn3     = dn_ext[cx +: 3];

  assign pat = {up3[0], up3[1], up3[2], mid3[0], mid3[2], dn3[0], dn3[1], dn3[2]};
  assign full_hit = full_rule(pat);

  assign gate_hit = gate_enable_r && (row_r == gate_row_r) &&
                    ({1'b0, col_r} >= {1'b0, gate_col_r}) &&
                    ({1'b0, col_r} <= ({1'b0, gate_col_r} + 6'd2));

  always_comb begin
    if (!in_grid) begin
      code_nxt = TILE_EMPTY;
    end else if (gate_hit) begin
      code_nxt = TILE_GATE_L + (col_r - gate_col_r);
    end else if (!mid3[1]) begin
      code_nxt = TILE_EMPTY;
    end else if (full_hit.hit) begin
      code_nxt = full_hit.code;
    end else begin
      code_nxt = orth_code({up3[1], mid3[0], mid3[2], dn3[1]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tile_code_r <= code_nxt;
    end
  end

`ifndef SYNTHESIS
  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  a_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> in_grid)
    else $error("memory write for a cell outside the grid");

  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.mem_wr))
    else $error("row memory read and written in the same cycle");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

### design/wall_tile_neighbourhood_classifier.sv
// Top level of the wall tile classifier: controller plus datapath.
// A query is decoded, makes three reads of the single-port row memory and is then
// classified; the next item is taken once its result is loaded, which waits while an
// earlier result is still untaken. A write reads, modifies and writes back its row;
// outside the grid neither touches the row memory. Synchronous active-low reset
// clears control state, loads gate defaults and marks every grid row as free.
module wall_tile_neighbourhood_classifier import wtnc_pkg::*; #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [4:0] in_row,
  input  logic [4:0] in_col,
  input  logic       in_cell_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_tile_code
);

  wtnc_cmd_t cmd;
  wtnc_sts_t sts;

  wtnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wtnc_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_tile_code (out_tile_code),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the wall tile classifier: directed table, then random traffic.
module testbench;
  import wtnc_pkg::*;

  localparam int ROWS         = 32;
  localparam int COLS         = 32;
  localparam int DRAIN_CYCLES = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1250;

  // Full-neighbourhood patterns (UL UM UR ML MR LL LM LR) and the tile each one selects.
  localparam logic [0:23][7:0] FULL_PAT = {
    8'hF8, 8'hF9, 8'hFC, 8'hFD, 8'h1F, 8'h9F, 8'h3F, 8'hBF,
    8'hFA, 8'h7B, 8'h5F, 8'hDE, 8'h6B, 8'h6F, 8'hEB, 8'hEF,
    8'hD6, 8'hD7, 8'hF6, 8'hF7, 8'hFB, 8'h7F, 8'hDF, 8'hFE
  };
  localparam logic [0:23][4:0] FULL_TILE = {
    TILE_HORIZ, TILE_HORIZ, TILE_HORIZ, TILE_HORIZ,
    TILE_HORIZ, TILE_HORIZ, TILE_HORIZ, TILE_HORIZ,
    TILE_TEE_UP, TILE_TEE_RIGHT, TILE_TEE_DOWN, TILE_TEE_LEFT,
    TILE_VERT, TILE_VERT, TILE_VERT, TILE_VERT,
    TILE_VERT, TILE_VERT, TILE_VERT, TILE_VERT,
    TILE_CORNER_LD, TILE_CORNER_LU, TILE_CORNER_UR, TILE_CORNER_DR
  };
  // Fallback by orthogonal neighbours {UM, ML, MR, LM}, entry 15 first.
  localparam logic [15:0][4:0] ORTH_TILE = {
    TILE_CROSS, TILE_TEE_DOWN, TILE_TEE_RIGHT, TILE_CORNER_LU,
    TILE_TEE_LEFT, TILE_CORNER_UR, TILE_VERT, TILE_END_DOWN,
    TILE_TEE_UP, TILE_HORIZ, TILE_CORNER_LD, TILE_END_RIGHT,
    TILE_CORNER_DR, TILE_END_LEFT, TILE_END_UP, TILE_ISOLATED
  };

  typedef struct packed {
    logic       is_cfg;
    logic       op;
    logic [4:0] row;
    logic [4:0] col;
    logic       value;
    logic       pinned;
    logic [4:0] tile;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       in_op;
  logic [4:0] in_row;
  logic [4:0] in_col;
  logic       in_cell_value;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] out_tile_code;

  // The tile code that travels with the item when the table gives one.
  logic       pin_valid;
  logic [4:0] pin_tile;

  logic       wall_m [ROWS][COLS];
  logic       gate_en_m;
  logic [4:0] gate_row_m;
  logic [4:0] gate_col_m;

  logic [4:0] tile_q [$];
  stim_row_t  table_q [$];
  logic [4:0] want_tile;
  int         fail_count;
  int         sent;
  int         results_seen;
  int         quiet;
  int         idle_pct;
  int         stall_pct;
  logic       calm;

  wall_tile_neighbourhood_classifier #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_cell_value(in_cell_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tile_code(out_tile_code)
  );

  always #2 clk = ~clk;

  function automatic logic wall_at(int r, int c);
    if (r < 0 || c < 0 || r >= ROWS || c >= COLS) return 1'b0;
    return wall_m[r][c];
  endfunction

  function automatic logic [4:0] tile_for(int r, int c);
    logic [7:0] nb;
    int         d;
    if (gate_en_m && r == int'(gate_row_m)) begin
      d = c - int'(gate_col_m);
      if (d >= 0 && d <= 2) return TILE_GATE_L + 5'(d);
    end
    if (!wall_at(r, c)) return TILE_EMPTY;
    nb = {wall_at(r - 1, c - 1), wall_at(r - 1, c), wall_at(r - 1, c + 1),
          wall_at(r, c - 1), wall_at(r, c + 1),
          wall_at(r + 1, c - 1), wall_at(r + 1, c), wall_at(r + 1, c + 1)};
    for (int k = 0; k < 24; k++) begin
      if (FULL_PAT[k] == nb) return FULL_TILE[k];
    end
    return ORTH_TILE[{nb[6], nb[4], nb[3], nb[1]}];
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return 31;
      2: return 1;
      3: return 30;
      default: return $urandom_range(31);
    endcase
  endfunction

  function automatic void add_row(logic is_cfg, logic op, logic [4:0] r, logic [4:0] c,
                                  logic v, logic pin, logic [4:0] tile);
    table_q.push_back('{is_cfg, op, r, c, v, pin, tile});
  endfunction

  task automatic send(logic op, logic [4:0] r, logic [4:0] c, logic v,
                      logic pin, logic [4:0] tile);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_row        <= r;
    in_col        <= c;
    in_cell_value <= v;
    pin_valid     <= pin;
    pin_tile      <= tile;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic maybe_gap();
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic item(logic op, int r, int c, logic v);
    send(op, 5'(r), 5'(c), v, 1'b0, TILE_EMPTY);
    maybe_gap();
  endtask

  // Register writes happen only with nothing in flight, so the queue must drain first.
  task automatic set_gates(logic en, logic [4:0] r, logic [4:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tile_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GATE_ENABLE;
    cfg_data  <= 5'(en);
    @(posedge clk);
    cfg_index <= CFG_GATE_ROW;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_GATE_COL;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we     <= 1'b0;
    gate_en_m  = en;
    gate_row_m = r;
    gate_col_m = c;
  endtask

  // Writes a 3x3 neighbourhood (in-grid cells only), queries its center, maybe a neighbour.
  task automatic neighbourhood_burst();
    int         r0;
    int         c0;
    int         bit_i;
    logic [7:0] nb;
    logic       ctr;
    logic       v;
    r0 = pick_coord();
    c0 = pick_coord();
    nb = $urandom_range(1) ? FULL_PAT[$urandom_range(23)] : 8'($urandom);
    if ($urandom_range(4) == 0) nb[$urandom_range(7)] ^= 1'b1;
    ctr = ($urandom_range(9) != 0);
    bit_i = 7;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) begin
          v = ctr;
        end else begin
          v = nb[bit_i];
          bit_i--;
        end
        if (r0 + dr >= 0 && r0 + dr < ROWS && c0 + dc >= 0 && c0 + dc < COLS)
          item(OP_WRITE, r0 + dr, c0 + dc, v);
      end
    end
    item(OP_QUERY, r0, c0, 1'($urandom));
    if ($urandom_range(1))
      item(OP_QUERY, (r0 + $urandom_range(2) + 31) % 32, (c0 + $urandom_range(2) + 31) % 32,
           1'($urandom));
  endtask

  task automatic random_mix();
    int sel;
    int c;
    sel = $urandom_range(99);
    if (sel < 55) begin
      neighbourhood_burst();
    end else if (sel < 80) begin
      item(OP_WRITE, $urandom_range(31), $urandom_range(31), 1'($urandom));
    end else if (sel < 90) begin
      item(OP_QUERY, $urandom_range(31), $urandom_range(31), 1'($urandom));
    end else begin
      // Aim at the gate row, one column either side of the three gate cells.
      c = int'(gate_col_m) + $urandom_range(4) - 1;
      if (c < 0) c = 0;
      if (c > 31) c = 31;
      item(OP_QUERY, gate_row_m, c, 1'($urandom));
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // Prediction on every input transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (in_op == OP_WRITE) begin
        if (int'(in_row) < ROWS && int'(in_col) < COLS) wall_m[in_row][in_col] = in_cell_value;
      end else begin
        tile_q.push_back(pin_valid ? pin_tile : tile_for(int'(in_row), int'(in_col)));
      end
    end
  end

  // Checking on every output transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tile_q.size() == 0) begin
        $error("tile_code: no result expected, actual %0d", out_tile_code);
        fail_count++;
      end else begin
        want_tile = tile_q.pop_front();
        if (want_tile !== out_tile_code) begin
          $error("tile_code: expected %0d, actual %0d", want_tile, out_tile_code);
          fail_count++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  initial begin
    logic held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (!held && results_seen >= 60) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int target;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_GATE_ENABLE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_op         = OP_WRITE;
    in_row        = '0;
    in_col        = '0;
    in_cell_value = 1'b0;
    pin_valid     = 1'b0;
    pin_tile      = TILE_EMPTY;
    fail_count    = 0;
    sent          = 0;
    results_seen  = 0;
    quiet         = 0;
    idle_pct      = 25;
    stall_pct     = 25;
    calm          = 1'b0;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        wall_m[r][c] = 1'b0;
    gate_en_m  = GATE_ENABLE_RST;
    gate_row_m = GATE_ROW_RST;
    gate_col_m = GATE_COL_RST;

    // Reset values first: empty grid, gates at row 11, columns 9 to 11.
    add_row(0, OP_QUERY, 0, 0, 0, 1, TILE_EMPTY);
    add_row(0, OP_QUERY, 31, 31, 1, 1, TILE_EMPTY);
    add_row(0, OP_QUERY, 11, 9, 0, 1, TILE_GATE_L);
    add_row(0, OP_QUERY, 11, 10, 0, 1, TILE_GATE_L + 5'd1);
    add_row(0, OP_QUERY, 11, 11, 0, 1, TILE_GATE_L + 5'd2);
    add_row(0, OP_QUERY, 11, 12, 0, 1, TILE_EMPTY);
    add_row(0, OP_WRITE, 0, 0, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 0, 0, 1, TILE_ISOLATED);
    add_row(0, OP_WRITE, 31, 31, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 31, 31, 0, 1, TILE_ISOLATED);
    // A wall under a gate cell still reads as the gate.
    add_row(0, OP_WRITE, 11, 10, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 11, 10, 0, 1, TILE_GATE_L + 5'd1);
    add_row(0, OP_WRITE, 0, 1, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 0, 0, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 1, 0, 0, TILE_EMPTY);
    add_row(0, OP_WRITE, 1, 0, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 0, 0, 0, TILE_EMPTY);
    add_row(0, OP_WRITE, 1, 1, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 0, 0, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 1, 1, 0, 0, TILE_EMPTY);
    add_row(0, OP_WRITE, 0, 0, 0, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 0, 0, 1, TILE_EMPTY);
    // Gating off exposes the lone wall at row 11, column 10.
    add_row(1, OP_WRITE, 11, 9, 0, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 11, 10, 0, 1, TILE_ISOLATED);
    add_row(1, OP_WRITE, 31, 29, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 31, 29, 0, 1, TILE_GATE_L);
    add_row(0, OP_QUERY, 31, 31, 0, 1, TILE_GATE_L + 5'd2);
    add_row(1, OP_WRITE, 0, 0, 1, 0, TILE_EMPTY);
    add_row(0, OP_QUERY, 0, 1, 0, 1, TILE_GATE_L + 5'd1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_q[i]) begin
      if (table_q[i].is_cfg) begin
        set_gates(table_q[i].value, table_q[i].row, table_q[i].col);
      end else begin
        send(table_q[i].op, table_q[i].row, table_q[i].col, table_q[i].value,
             table_q[i].pinned, table_q[i].tile);
        maybe_gap();
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_gates(1'b1, 5'd0, 5'd0);
        1: set_gates(1'b1, 5'd31, 5'd29);
        2: set_gates(1'b0, 5'd31, 5'd0);
        default: set_gates($urandom_range(3) != 0, 5'($urandom_range(31)),
                           5'($urandom_range(29)));
      endcase
      idle_pct  = pick_pct();
      stall_pct = pick_pct();
      target = sent + (RANDOM_ITEMS - 150) / 10;
      while (sent < target) random_mix();
    end

    // Closing stretch runs at full rate on both sides.
    set_gates(1'b1, 5'($urandom_range(31)), 5'($urandom_range(29)));
    calm      = 1'b1;
    idle_pct  = 0;
    stall_pct = 0;
    target = sent + 150;
    while (sent < target) random_mix();

    in_valid <= 1'b0;
    @(posedge clk);
    while (tile_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && tile_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
design/wtnc_pkg.sv
design/wtnc_ctrl.sv
design/wtnc_dp.sv
design/wall_tile_neighbourhood_classifier.sv
tb/testbench.sv
